FILE: rtl/erc_pkg.sv
// shared types, codes and helpers for the elevator request controller
`timescale 1ns / 1ps
package erc_pkg;

  localparam int FloorSlotsDef = 64;
  localparam int FloorW        = 6;
  localparam int KindW         = 2;
  localparam int DirW          = 2;
  localparam int StatusW       = 2;
  localparam int CfgIdxW       = 2;
  localparam int InDataW       = 8;
  localparam int OutDataW      = 24;

  typedef logic signed [FloorW-1:0] floor_t;

  typedef enum logic [KindW-1:0] {
    KIND_ADD   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [DirW-1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED     = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ADD   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOWEST  = 2'd0,
    CFG_HIGHEST = 2'd1,
    CFG_START   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    floor_t           floor;
    logic             call_dir;
  } item_t;

  typedef struct packed {
    floor_t lowest;
    floor_t highest;
    floor_t start;
    logic   load;
  } cfg_t;

  typedef struct packed {
    logic          none_pending;
    logic          can_serve;
    logic [StatusW-1:0] add_status;
    floor_t        next_target;
    logic [DirW-1:0] car_dir;
    floor_t        car_floor;
  } result_t;

  // slot s holds floor s - 32
  function automatic floor_t slot_floor(input int s);
    return floor_t'(FloorW'(s) ^ 6'h20);
  endfunction

endpackage

FILE: rtl/elevator_request_controller_core.sv
// Single-car elevator request controller, top level
//
// Input stream s_t*: one word per event. tuser carries the kind (add request,
// step tick, serve query), tdata the floor and the hall call direction.
// Output stream m_t*: exactly one result word per input word, in order, with
// car floor, direction, front target, add status, query answer and empty flag.
// Config channel cfg_*: index 0 lowest floor, 1 highest floor, 2 start floor
// (also loads the car position); always ready, write only while idle.
// A word in the input register is evaluated once the result register is free
// or being taken, and its result is shown from then on. One word per cycle is
// sustained while the receiver is ready; the request bitmap and its priority
// encoders settle each word combinationally. Reset clears all requests, puts
// the car idle on floor 0 and sets the limits to 0 and 31. On a receiver stall
// the result register holds and s_tready drops once the input register is full.
`timescale 1ns / 1ps
module elevator_request_controller_core import erc_pkg::*; #(
  parameter int FloorSlots = FloorSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // floor[5:0], call_dir[6], zero[7]
  input  logic [KindW-1:0]    s_tuser,   // kind[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // car_floor[5:0], car_dir[7:6],
                                         // next_target[13:8], add_status[15:14],
                                         // can_serve[16], none_pending[17], zero[23:18]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [FloorW-1:0]   cfg_data_i
);

  item_t   item_q;
  logic    in_v_q;
  result_t res_d, res_q;
  logic    out_v_q;
  logic    fire;
  logic    cfg_wr;
  floor_t  lowest_q, highest_q;
  cfg_t    cfg;

  assign fire     = in_v_q && (!out_v_q || m_tready);
  assign s_tready = !in_v_q || fire;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= '0;
      highest_q <= floor_t'(31);
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOWEST:  lowest_q  <= floor_t'(cfg_data_i);
        CFG_HIGHEST: highest_q <= floor_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg.lowest  = lowest_q;
  assign cfg.highest = highest_q;
  assign cfg.start   = floor_t'(cfg_data_i);
  assign cfg.load    = cfg_wr && (cfg_index_i == CFG_START);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_tready) begin
      in_v_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      item_q.kind     <= s_tuser;
      item_q.floor    <= floor_t'(s_tdata[5:0]);
      item_q.call_dir <= s_tdata[6];
    end
  end

  erc_engine #(.FloorSlots(FloorSlots)) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= 1'b1;
    end else if (m_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign m_tvalid = out_v_q;
  assign m_tdata  = {6'b0, res_q.none_pending, res_q.can_serve, res_q.add_status,
                     res_q.next_target, res_q.car_dir, res_q.car_floor};

endmodule

FILE: rtl/erc_front.sv
// priority encoder that finds the front requested floor in the request bitmap
`timescale 1ns / 1ps
module erc_front import erc_pkg::*; #(
  parameter int FloorSlots = FloorSlotsDef
) (
  input  logic [FloorSlots-1:0] map_i,
  input  logic                  desc_i,
  output logic                  any_o,
  output floor_t                floor_o
);

  always_comb begin
    floor_o = '0;
    if (desc_i) begin
      // last hit wins: highest set slot
      for (int i = 0; i < FloorSlots; i++) begin
        if (map_i[i]) floor_o = slot_floor(i);
      end
    end else begin
      for (int i = FloorSlots - 1; i >= 0; i--) begin
        if (map_i[i]) floor_o = slot_floor(i);
      end
    end
  end

  assign any_o = |map_i;

endmodule

FILE: rtl/erc_engine.sv
// request bitmap, car state and the combinational update for one word
`timescale 1ns / 1ps
module erc_engine import erc_pkg::*; #(
  parameter int FloorSlots = FloorSlotsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [FloorSlots-1:0] map_q, map_d, map1;
  logic                  desc_q, desc_d;
  floor_t                cur_q, cur_d;
  dir_e                  dir_q, dir_d;

  logic [FloorSlots-1:0] mask_add, mask_cur;
  logic                  any_a, any_b, any_c;
  floor_t                front_a, front_b, front_c;
  logic                  in_range;
  status_e               status;
  logic                  serve;

  // one-hot slot mask of a floor, zero when the floor has no slot
  function automatic logic [FloorSlots-1:0] slot_mask(input floor_t f);
    logic [FloorSlots-1:0] m;
    m = '0;
    for (int i = 0; i < FloorSlots; i++) begin
      m[i] = (9'(i) == {3'b000, ~f[5], f[4:0]});
    end
    return m;
  endfunction

  erc_front #(.FloorSlots(FloorSlots)) u_front_a (
    .map_i(map_q), .desc_i(desc_q), .any_o(any_a), .floor_o(front_a)
  );

  // front after a possible clear at the current floor
  erc_front #(.FloorSlots(FloorSlots)) u_front_b (
    .map_i(map1), .desc_i(desc_q), .any_o(any_b), .floor_o(front_b)
  );

  erc_front #(.FloorSlots(FloorSlots)) u_front_c (
    .map_i(map_d), .desc_i(desc_d), .any_o(any_c), .floor_o(front_c)
  );

  assign mask_add = slot_mask(item_i.floor);
  assign mask_cur = slot_mask(cur_q);
  assign map1     = (front_a == cur_q) ? (map_q & ~mask_cur) : map_q;
  assign in_range = (item_i.floor >= cfg_i.lowest) && (item_i.floor <= cfg_i.highest);

  always_comb begin
    map_d  = map_q;
    desc_d = desc_q;
    cur_d  = cur_q;
    dir_d  = dir_q;
    status = ST_NOT_ADD;
    serve  = 1'b0;
    case (kind_e'(item_i.kind))
      KIND_ADD: begin
        if (!in_range || !(|mask_add)) begin
          status = ST_RANGE;
        end else if (|(map_q & mask_add)) begin
          status = ST_DUPLICATE;
        end else begin
          status = ST_ADDED;
          map_d  = map_q | mask_add;
          desc_d = (dir_q == DIR_DOWN);
        end
      end
      KIND_TICK: begin
        if (!any_a) begin
          dir_d = DIR_IDLE;
        end else begin
          map_d = map1;
          if (any_b) begin
            if (front_b > cur_q) begin
              dir_d = DIR_UP;
              cur_d = cur_q + floor_t'(1);
              map_d = map1 & ~slot_mask(cur_d);
            end else if (front_b < cur_q) begin
              dir_d = DIR_DOWN;
              cur_d = cur_q - floor_t'(1);
              map_d = map1 & ~slot_mask(cur_d);
            end else begin
              dir_d = DIR_IDLE;
            end
          end
        end
      end
      KIND_QUERY: begin
        serve = (dir_q == DIR_IDLE) ||
                (!item_i.call_dir && dir_q != DIR_DOWN) ||
                (item_i.call_dir && dir_q != DIR_UP);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      desc_q <= 1'b0;
      cur_q  <= '0;
      dir_q  <= DIR_IDLE;
    end else if (cfg_i.load) begin
      cur_q <= cfg_i.start;
    end else if (fire_i) begin
      map_q  <= map_d;
      desc_q <= desc_d;
      cur_q  <= cur_d;
      dir_q  <= dir_d;
    end
  end

  assign res_o.car_floor    = cur_d;
  assign res_o.car_dir      = dir_d;
  assign res_o.next_target  = any_c ? front_c : cur_d;
  assign res_o.add_status   = status;
  assign res_o.can_serve    = serve;
  assign res_o.none_pending = !any_c;

  a_one_floor_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.load |=> (cur_q == $past(cur_q) ||
      cur_q == $past(cur_q) + floor_t'(1) || cur_q == $past(cur_q) - floor_t'(1)))
    else $error("car moved more than one floor");

  a_only_add_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.kind != KIND_ADD |=> (map_q & ~$past(map_q)) == '0)
    else $error("request bit set by a non-add word");

  a_add_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.load && status == ST_ADDED |=> $countones(map_q ^ $past(map_q)) == 1)
    else $error("add did not set exactly one bit");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(map_q) && $stable(dir_q))
    else $error("state changed without a word");

endmodule
